>>> rtl/core/rrep_pkg.sv
package rrep_pkg;

    localparam int WORD_BITS = 32;

    // r + g + b of a fully white pixel
    localparam logic [9:0] WHITE_SUM = 10'd765;

    // floor(dark * 256 / 765) == (dark * RECIP) >> RECIP_SHIFT for dark in 0..765
    localparam int         RECIP_SHIFT = 20;
    localparam logic [18:0] RECIP      = 19'd350897;

    localparam logic [15:0] HEIGHT_RESET = 16'd1024;

    // configuration register indexes
    localparam logic [1:0] CFG_LEVEL_BITS   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [15:0] row_coord;
        logic [7:0]  start_x;
        logic [7:0]  end_x;
        logic [7:0]  column_count;
        logic        reverse;
    } t_row_hdr;

    // bits per level, 1..8
    function automatic logic [3:0] level_bits(input logic [1:0] bits_log2);
        level_bits = 4'd1 << bits_log2;
    endfunction

    // largest level at the given bit count
    function automatic logic [8:0] level_top(input logic [1:0] bits_log2);
        level_top = (9'd1 << level_bits(bits_log2)) - 9'd1;
    endfunction

endpackage

>>> rtl/core/raster_row_engrave_packer_unit.sv
// Pixels are taken one per cycle while busy is low; a row end queues the row for packing in
// the next cycle if it holds engraved pixels. The packer reads one stored level per cycle.
// busy rises while two rows wait in the queue, which is when both line buffer banks are taken.
// Synchronous active-low reset clears counters, queue and direction; the line buffer is not
// cleared and needs no clearing pass. Results cannot be stalled by the receiver.
module raster_row_engrave_packer_unit #(
    parameter int MAX_WIDTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_pixel_red,
    input  logic [7:0]  i_pixel_green,
    input  logic [7:0]  i_pixel_blue,
    input  logic        i_row_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic [15:0] o_row_coord,
    output logic [7:0]  o_start_x,
    output logic [7:0]  o_end_x,
    output logic [7:0]  o_column_count,
    output logic [31:0] o_data_word,
    output logic        o_last
);

    import rrep_pkg::*;

    localparam int IDXW = $clog2(MAX_WIDTH);
    localparam int QW   = $bits(t_row_hdr) + 2 * IDXW;

    // configuration registers
    logic [1:0]  r_level_bits_log2;
    logic [15:0] r_image_height;

    // front to queue
    logic            accept;
    logic            push;
    t_row_hdr        push_hdr;
    logic [IDXW-1:0] push_first;
    logic [IDXW-1:0] push_last;

    // queue to back
    logic [QW-1:0]   q_data;
    logic            q_valid;
    logic            q_full;
    logic            q_wr_ptr;
    logic            q_rd_ptr;
    logic            pop;
    t_row_hdr        q_hdr;
    logic [IDXW-1:0] q_first;
    logic [IDXW-1:0] q_last;

    // line buffer ports
    logic            ram_we;
    logic [IDXW:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [IDXW:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    // take a pixel only while a bank is free for it
    assign busy        = q_full;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // hold the registers; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_bits_log2 <= 2'd0;
            r_image_height    <= HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LEVEL_BITS:   r_level_bits_log2 <= i_cfg_data[1:0];
                CFG_IMAGE_HEIGHT: r_image_height    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classify each pixel, store its level and track the dark span of the row
    rrep_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_pixel_red       (i_pixel_red),
        .i_pixel_green     (i_pixel_green),
        .i_pixel_blue      (i_pixel_blue),
        .i_row_end         (i_row_end),
        .i_level_bits_log2 (r_level_bits_log2),
        .i_image_height    (r_image_height),
        .i_bank            (q_wr_ptr),
        .o_ram_we          (ram_we),
        .o_ram_waddr       (ram_waddr),
        .o_ram_wdata       (ram_wdata),
        .o_push            (push),
        .o_hdr             (push_hdr),
        .o_first           (push_first),
        .o_last            (push_last)
    );

    // two row banks, one being filled while the other is packed
    rrep_ram #(
        .WIDTH(8),
        .DEPTH(2 << IDXW)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // queued rows; a row leaves once its final word is out
    rrep_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   ({push_hdr, push_first, push_last}),
        .i_pop    (pop),
        .o_data   (q_data),
        .o_valid  (q_valid),
        .o_full   (q_full),
        .o_wr_ptr (q_wr_ptr),
        .o_rd_ptr (q_rd_ptr)
    );

    assign {q_hdr, q_first, q_last} = q_data;

    // walk the row in serpentine order and pack levels into words
    rrep_back #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (q_valid),
        .i_bank            (q_rd_ptr),
        .i_hdr             (q_hdr),
        .i_first           (q_first),
        .i_last            (q_last),
        .i_level_bits_log2 (r_level_bits_log2),
        .i_ram_rdata       (ram_rdata),
        .o_ram_raddr       (ram_raddr),
        .o_pop             (pop),
        .o_strobe          (o_strobe),
        .o_row_coord       (o_row_coord),
        .o_start_x         (o_start_x),
        .o_end_x           (o_end_x),
        .o_column_count    (o_column_count),
        .o_data_word       (o_data_word),
        .o_last            (o_last)
    );

endmodule

>>> rtl/core/rrep_ram.sv
module rrep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/rrep_queue.sv
module rrep_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full,
    output logic             o_wr_ptr,
    output logic             o_rd_ptr
);

    // two slots; the slot number doubles as the line buffer bank of the row
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign push_ok = i_push && (r_cnt != 2'd2);
    assign pop_ok  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data   = r_mem[r_rp];
    assign o_valid  = (r_cnt != 2'd0);
    assign o_full   = (r_cnt == 2'd2);
    assign o_wr_ptr = r_wp;
    assign o_rd_ptr = r_rp;

endmodule

>>> rtl/core/rrep_front.sv
module rrep_front #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [7:0]                     i_pixel_red,
    input  logic [7:0]                     i_pixel_green,
    input  logic [7:0]                     i_pixel_blue,
    input  logic                           i_row_end,
    input  logic [1:0]                     i_level_bits_log2,
    input  logic [15:0]                    i_image_height,
    input  logic                           i_bank,
    output logic                           o_ram_we,
    output logic [$clog2(MAX_WIDTH):0]     o_ram_waddr,
    output logic [7:0]                     o_ram_wdata,
    output logic                           o_push,
    output rrep_pkg::t_row_hdr             o_hdr,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_first,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_last
);

    import rrep_pkg::*;

    localparam int IDXW = $clog2(MAX_WIDTH);
    localparam int CW   = IDXW + 1;

    logic [CW-1:0]   r_first;
    logic [IDXW-1:0] r_last;
    logic [CW-1:0]   r_count;
    logic [15:0]     r_row_index;
    logic            r_reverse;

    logic [CW-1:0]   n_first;
    logic [IDXW-1:0] n_last;
    logic [IDXW-1:0] idx;
    logic            in_row;
    logic            nonwhite;
    logic            engrave;
    logic [9:0]      sum;
    logic [9:0]      dark;
    logic [28:0]     prod;
    logic [8:0]      q8;
    logic [8:0]      q_sh;
    logic [8:0]      top;
    logic [IDXW-1:0] cols;
    logic [15:0]     coord;

    assign sum  = 10'(i_pixel_red) + 10'(i_pixel_green) + 10'(i_pixel_blue);
    assign dark = WHITE_SUM - sum;
    assign prod = 29'(dark) * 29'(RECIP);
    assign q8   = prod[RECIP_SHIFT +: 9];
    assign q_sh = q8 >> (4'd8 - level_bits(i_level_bits_log2));
    assign top  = level_top(i_level_bits_log2);

    assign idx      = r_count[IDXW-1:0];
    assign in_row   = (r_count < CW'(MAX_WIDTH));
    assign nonwhite = (sum != WHITE_SUM);

    always_comb begin
        n_first = r_first;
        n_last  = r_last;
        if (in_row && nonwhite) begin
            if (r_first >= CW'(MAX_WIDTH)) begin
                n_first = {1'b0, idx};
            end
            if (idx != '0) begin
                n_last = idx;
            end
        end
    end

    assign engrave = (CW'(n_last) > n_first);
    assign cols    = n_last - n_first[IDXW-1:0];
    assign coord   = (i_image_height > r_row_index) ? (i_image_height - r_row_index) : 16'd0;

    always_comb begin
        o_hdr.row_coord    = coord;
        o_hdr.start_x      = r_reverse ? 8'(n_last) : 8'(n_first[IDXW-1:0]);
        o_hdr.end_x        = r_reverse ? 8'(n_first[IDXW-1:0]) : 8'(n_last);
        o_hdr.column_count = 8'(cols);
        o_hdr.reverse      = r_reverse;
    end

    assign o_first = n_first[IDXW-1:0];
    assign o_last  = n_last;
    assign o_push  = i_accept && i_row_end && engrave;

    assign o_ram_we    = i_accept && in_row;
    assign o_ram_waddr = {i_bank, idx};
    assign o_ram_wdata = (q_sh > top) ? top[7:0] : q_sh[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= CW'(MAX_WIDTH);
            r_last      <= '0;
            r_count     <= '0;
            r_row_index <= '0;
            r_reverse   <= 1'b0;
        end else if (i_accept) begin
            if (i_row_end) begin
                r_first     <= CW'(MAX_WIDTH);
                r_last      <= '0;
                r_count     <= '0;
                r_row_index <= r_row_index + 16'd1;
                if (engrave) begin
                    r_reverse <= ~r_reverse;
                end
            end else begin
                r_first <= n_first;
                r_last  <= n_last;
                if (in_row) begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

endmodule

>>> rtl/core/rrep_back.sv
module rrep_back #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_bank,
    input  rrep_pkg::t_row_hdr             i_hdr,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_first,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_last,
    input  logic [1:0]                     i_level_bits_log2,
    input  logic [7:0]                     i_ram_rdata,
    output logic [$clog2(MAX_WIDTH):0]     o_ram_raddr,
    output logic                           o_pop,
    output logic                           o_strobe,
    output logic [15:0]                    o_row_coord,
    output logic [7:0]                     o_start_x,
    output logic [7:0]                     o_end_x,
    output logic [7:0]                     o_column_count,
    output logic [31:0]                    o_data_word,
    output logic                           o_last
);

    import rrep_pkg::*;

    localparam int IDXW = $clog2(MAX_WIDTH);
    localparam int CW   = IDXW + 1;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_i;
    logic            r_dvld;
    logic            r_dfin;
    logic [31:0]     r_word;
    logic [5:0]      r_c;

    logic [CW-1:0]   n_total;
    logic            issue;
    logic [IDXW-1:0] x;
    logic [8:0]      top_lvl;
    logic [7:0]      lvl;
    logic [31:0]     n_word;
    logic [5:0]      n_c;
    logic            emit;

    assign n_total = CW'(i_last - i_first) + CW'(1);
    assign issue   = (r_state == S_RUN) && (r_i < n_total);
    assign x       = i_hdr.reverse ? (i_last - r_i[IDXW-1:0]) : (i_first + r_i[IDXW-1:0]);
    assign o_ram_raddr = {i_bank, x};

    assign top_lvl = level_top(i_level_bits_log2);
    assign lvl     = i_ram_rdata & top_lvl[7:0];
    assign n_word  = r_word | (32'(lvl) << r_c);
    assign n_c     = r_c + 6'(level_bits(i_level_bits_log2));
    assign emit    = r_dvld && ((n_c >= 6'(WORD_BITS)) || r_dfin);
    assign o_pop   = r_dvld && r_dfin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dvld   <= 1'b0;
            r_dfin   <= 1'b0;
            r_i      <= '0;
            r_c      <= '0;
            r_word   <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= emit;
            r_dvld   <= issue;
            r_dfin   <= issue && (r_i == n_total - CW'(1));
            if (issue) begin
                r_i <= r_i + CW'(1);
            end
            if (r_dvld) begin
                if (emit) begin
                    r_word <= '0;
                    r_c    <= '0;
                end else begin
                    r_word <= n_word;
                    r_c    <= n_c;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_RUN;
                        r_i     <= '0;
                        r_word  <= '0;
                        r_c     <= '0;
                    end
                end
                S_RUN: begin
                    if (o_pop) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_row_coord    <= i_hdr.row_coord;
            o_start_x      <= i_hdr.start_x;
            o_end_x        <= i_hdr.end_x;
            o_column_count <= i_hdr.column_count;
            o_data_word    <= n_word;
            o_last         <= r_dfin;
        end
    end

endmodule
